// ===== design/mlfq_pkg.sv =====
// Package of the multilevel feedback queue scheduler: word types, command,
// status, priority and register codes, register reset values.
// No dependencies.
package mlfq_pkg;

  localparam int unsigned MAX_PROCS_DEF = 16;

  // command codes
  localparam logic [2:0] MODE_SPAWN  = 3'd0;
  localparam logic [2:0] MODE_DEATH  = 3'd1;
  localparam logic [2:0] MODE_SELECT = 3'd2;
  localparam logic [2:0] MODE_YIELD  = 3'd3;
  localparam logic [2:0] MODE_WAIT   = 3'd4;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOREADY = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_UNKNOWN = 2'd3;

  // priorities, also the ring numbers
  localparam logic [1:0] PRI_TOP = 2'd0;
  localparam logic [1:0] PRI_MID = 2'd1;
  localparam logic [1:0] PRI_BOT = 2'd2;

  // run states
  localparam logic [1:0] RUN_READY = 2'd0;
  localparam logic [1:0] RUN_RUN   = 2'd1;
  localparam logic [1:0] RUN_WAIT  = 2'd2;

  // register indexes
  localparam logic [2:0] CFG_THR_MED  = 3'd0;
  localparam logic [2:0] CFG_THR_LOW  = 3'd1;
  localparam logic [2:0] CFG_ALPHA    = 3'd2;
  localparam logic [2:0] CFG_BETA     = 3'd3;
  localparam logic [2:0] CFG_BASE_Q   = 3'd4;
  localparam logic [2:0] CFG_DIV_MED  = 3'd5;
  localparam logic [2:0] CFG_DIV_LOW  = 3'd6;

  // register reset values
  localparam logic [47:0] THR_MED_RST = 48'd1250000000;
  localparam logic [47:0] THR_LOW_RST = 48'd1500000000;
  localparam logic [3:0]  ALPHA_RST   = 4'd2;
  localparam logic [3:0]  BETA_RST    = 4'd3;
  localparam logic [31:0] BASE_Q_RST  = 32'd10000000;
  localparam logic [3:0]  DIV_MED_RST = 4'd2;
  localparam logic [3:0]  DIV_LOW_RST = 4'd3;

  localparam logic [61:0] NS_PER_SEC = 62'd1000000000;

  typedef struct packed {
    logic [2:0]  mode;
    logic [15:0] process_id;
    logic [31:0] now_sec;
    logic [29:0] now_ns;
    logic [47:0] burst_cpu;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] selected_process;
    logic [31:0] quantum;
    logic [1:0]  priority_res;
    logic [62:0] burst_wait;
  } rsp_t;

  typedef struct packed {
    logic [2:0]  index;
    logic [47:0] data;
  } cfg_t;

endpackage

// ===== design/mlfq_chan_if.sv =====
// Valid/ready channel carrying one word of type T.
// Used with the word types of mlfq_pkg.
interface mlfq_chan_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== design/mlfq_div.sv =====
// Restoring divider, one quotient bit a cycle.
// Stand-alone; used by the scheduler top level.
module mlfq_div #(
  parameter int unsigned DW = 64,
  parameter int unsigned VW = 9
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  output logic          busy_o,
  output logic          done_o,
  output logic [DW-1:0] quotient_o
);
  localparam int unsigned CW = $clog2(DW + 1);

  logic [DW-1:0] quo_q;
  logic [VW-1:0] rem_q;
  logic [VW-1:0] div_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q;
  logic          done_q;
  logic [VW:0]   trial;
  logic          fits;

  // trial subtract of the next partial remainder
  assign trial = {rem_q, quo_q[DW-1]};
  assign fits  = trial >= {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quo_q  <= '0;
      rem_q  <= '0;
      div_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        quo_q  <= dividend_i;
        rem_q  <= '0;
        div_q  <= divisor_i;
        cnt_q  <= CW'(DW);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        rem_q <= fits ? VW'(trial - {1'b0, div_q}) : trial[VW-1:0];
        quo_q <= {quo_q[DW-2:0], fits};
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = quo_q;
endmodule

// ===== design/multilevel_feedback_queue_scheduler_unit.sv =====
// Three-level feedback queue scheduler: process table, ready rings, registers.
// Depends on mlfq_pkg, mlfq_chan_if and mlfq_div.
//
//   channel  dir  word    accepted when
//   cmd_i    in   cmd_t   valid && ready
//   rsp_o    out  rsp_t   valid && ready
//   cfg_i    in   cfg_t   valid && ready (ready always high)
//
// One command at a time. Spawn, wait, unused modes and lookup errors pass
// through S_NOW to S_DONE; a stale select also reads the ring, death scans
// its ring and compacts it through the ring memory, select waits on the
// 64-step divider, and yield computes the burst wait, then runs up to two
// average scans through both memories, each with a divide.
// Reset clears the table valid bits and ring pointers; no clearing pass.
// A finished word waits in the output register; a new command is taken
// meanwhile and its result is held until the old word leaves.
module multilevel_feedback_queue_scheduler_unit #(
  parameter int unsigned MAX_PROCS = mlfq_pkg::MAX_PROCS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  mlfq_chan_if.sink    cmd_i,
  mlfq_chan_if.source  rsp_o,
  mlfq_chan_if.sink    cfg_i
);
  import mlfq_pkg::*;

  localparam int unsigned IW  = $clog2(MAX_PROCS);
  localparam int unsigned LW  = $clog2(MAX_PROCS + 1);
  localparam int unsigned RAW = $clog2(3 * MAX_PROCS);
  localparam int unsigned VW  = (LW > 4) ? LW : 4;

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_NOW     = 5'd1;
  localparam logic [4:0] S_RM_RD   = 5'd2;
  localparam logic [4:0] S_RM_CHK  = 5'd3;
  localparam logic [4:0] S_SH_RD   = 5'd4;
  localparam logic [4:0] S_SH_WR   = 5'd5;
  localparam logic [4:0] S_SEL_RD  = 5'd6;
  localparam logic [4:0] S_SEL_DIV = 5'd7;
  localparam logic [4:0] S_Y_SUB   = 5'd8;
  localparam logic [4:0] S_Y_CALC  = 5'd9;
  localparam logic [4:0] S_Y_WR    = 5'd10;
  localparam logic [4:0] S_AV_RD   = 5'd11;
  localparam logic [4:0] S_AV_ENT  = 5'd12;
  localparam logic [4:0] S_AV_ACC  = 5'd13;
  localparam logic [4:0] S_AV_DIV  = 5'd14;
  localparam logic [4:0] S_AV_MUL  = 5'd15;
  localparam logic [4:0] S_AV_CMP  = 5'd16;
  localparam logic [4:0] S_PUSH    = 5'd17;
  localparam logic [4:0] S_DONE    = 5'd18;

  typedef struct packed {
    logic [63:0] last;
    logic [63:0] wait_sum;
  } ent_t;

  function automatic logic [IW-1:0] pinc(input logic [IW-1:0] p);
    return (p == IW'(MAX_PROCS - 1)) ? '0 : IW'(p + 1'b1);
  endfunction

  function automatic logic [IW-1:0] pdec(input logic [IW-1:0] p);
    return (p == '0) ? IW'(MAX_PROCS - 1) : IW'(p - 1'b1);
  endfunction

  function automatic logic [RAW-1:0] raddr(input logic [1:0] q, input logic [IW-1:0] p);
    return RAW'(q * MAX_PROCS + p);
  endfunction

  // configuration registers
  logic [47:0] thr_med_q, thr_low_q;
  logic [3:0]  alpha_q, beta_q, div_med_q, div_low_q;
  logic [31:0] base_q_q;

  // control and table flags
  logic [4:0]    state_q;
  logic          valid_q [MAX_PROCS];
  logic [1:0]    run_q   [MAX_PROCS];
  logic [1:0]    prio_q  [MAX_PROCS];
  logic [15:0]   proc_q  [MAX_PROCS];
  logic [IW-1:0] head_q  [3];
  logic [IW-1:0] tail_q  [3];
  logic [LW-1:0] len_q   [3];
  logic          disp_valid_q;
  logic [15:0]   disp_proc_q;
  logic          rsp_valid_q;
  rsp_t          rsp_data_q;

  // per-command working registers
  cmd_t          cmd_q;
  rsp_t          res_q;
  logic [61:0]   mul_q;
  logic [63:0]   now_q, nc_q, w_q, sum_q, avg_q;
  logic          nc_ok_q;
  logic [67:0]   prod_q;
  logic [IW-1:0] e_q, pos_q;
  logic [LW-1:0] k_q;
  logic [1:0]    rq_q, p_q;

  // memories
  ent_t          ent_mem [MAX_PROCS];
  ent_t          ent_rd_q;
  logic [IW-1:0] ring_mem [3 * MAX_PROCS];
  logic [IW-1:0] ring_rd_q;

  logic          ent_we, ent_re, ring_we, ring_re;
  logic [IW-1:0] ent_waddr, ent_raddr, ring_wdata;
  ent_t          ent_wdata;
  logic [RAW-1:0] ring_waddr, ring_raddr;

  logic          div_start, div_busy, div_done;
  logic [63:0]   div_dividend, div_quo;
  logic [VW-1:0] div_divisor;

  logic          look_found, free_found, sel_any;
  logic [IW-1:0] look_idx, free_idx;
  logic [1:0]    sel_q, push_q;
  logic [IW-1:0] push_pos;
  logic          push_ok;
  logic [LW-1:0] rlen;
  logic [63:0]   now_d;
  logic [3:0]    dsel;

  // lowest matching and lowest free entry
  always_comb begin
    look_found = 1'b0;
    look_idx   = '0;
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = MAX_PROCS - 1; i >= 0; i--) begin
      if (valid_q[i] && proc_q[i] == cmd_q.process_id) begin
        look_found = 1'b1;
        look_idx   = IW'(i);
      end
      if (!valid_q[i]) begin
        free_found = 1'b1;
        free_idx   = IW'(i);
      end
    end
  end

  // highest non-empty ring, push slot, divisor choice
  always_comb begin
    sel_any = 1'b1;
    if (len_q[PRI_TOP] != '0)      sel_q = PRI_TOP;
    else if (len_q[PRI_MID] != '0) sel_q = PRI_MID;
    else begin
      sel_q   = PRI_BOT;
      sel_any = len_q[PRI_BOT] != '0;
    end
    push_q   = (state_q == S_NOW) ? PRI_TOP : p_q;
    push_ok  = len_q[push_q] < LW'(MAX_PROCS);
    push_pos = (len_q[push_q] == '0) ? '0 : pinc(tail_q[push_q]);
    rlen     = len_q[rq_q];
    now_d    = {2'b00, mul_q} + 64'(cmd_q.now_ns);
    if (prio_q[ring_rd_q] == PRI_MID)      dsel = div_med_q;
    else if (prio_q[ring_rd_q] == PRI_BOT) dsel = div_low_q;
    else                                   dsel = 4'd1;
    if (dsel == 4'd0) dsel = 4'd1;
  end

  // memory ports and divider start
  always_comb begin
    ent_we       = 1'b0;
    ent_waddr    = '0;
    ent_wdata    = '0;
    ent_re       = 1'b0;
    ent_raddr    = '0;
    ring_we      = 1'b0;
    ring_waddr   = '0;
    ring_wdata   = '0;
    ring_re      = 1'b0;
    ring_raddr   = '0;
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    unique case (state_q)
      S_NOW: begin
        if (cmd_q.mode == MODE_SPAWN && free_found) begin
          ent_we    = 1'b1;
          ent_waddr = free_idx;
          ent_wdata = '{last: now_d, wait_sum: 64'd0};
          if (push_ok) begin
            ring_we    = 1'b1;
            ring_waddr = raddr(PRI_TOP, push_pos);
            ring_wdata = free_idx;
          end
        end else if (cmd_q.mode == MODE_SELECT && sel_any) begin
          ring_re    = 1'b1;
          ring_raddr = raddr(sel_q, head_q[sel_q]);
        end else if (cmd_q.mode == MODE_YIELD && look_found) begin
          ent_re    = 1'b1;
          ent_raddr = look_idx;
        end
      end
      S_RM_RD: begin
        ring_re    = k_q != rlen;
        ring_raddr = raddr(rq_q, pos_q);
      end
      S_SH_RD: begin
        ring_re    = ({1'b0, k_q} + 1'b1) < {1'b0, rlen};
        ring_raddr = raddr(rq_q, pinc(pos_q));
      end
      S_SH_WR: begin
        ring_we    = 1'b1;
        ring_waddr = raddr(rq_q, pos_q);
        ring_wdata = ring_rd_q;
      end
      S_SEL_RD: begin
        div_start    = valid_q[ring_rd_q];
        div_dividend = 64'(base_q_q);
        div_divisor  = VW'(dsel);
      end
      S_Y_WR: begin
        ent_we    = 1'b1;
        ent_waddr = e_q;
        ent_wdata = '{last: (run_q[e_q] == RUN_RUN) ? now_q : ent_rd_q.last,
                      wait_sum: ent_rd_q.wait_sum + w_q};
      end
      S_AV_RD: begin
        if (k_q == rlen) begin
          div_start    = rlen != '0;
          div_dividend = sum_q;
          div_divisor  = VW'(rlen);
        end else begin
          ring_re    = 1'b1;
          ring_raddr = raddr(rq_q, pos_q);
        end
      end
      S_AV_ENT: begin
        ent_re    = 1'b1;
        ent_raddr = ring_rd_q;
      end
      S_PUSH: begin
        ring_we    = push_ok;
        ring_waddr = raddr(p_q, push_pos);
        ring_wdata = e_q;
      end
      default: ;
    endcase
  end

  // entry memory: last burst end and total wait
  always_ff @(posedge clk_i) begin
    if (ent_we) ent_mem[ent_waddr] <= ent_wdata;
    if (ent_re) ent_rd_q <= ent_mem[ent_raddr];
  end

  // ring memory: three rings of entry indices
  always_ff @(posedge clk_i) begin
    if (ring_we) ring_mem[ring_waddr] <= ring_wdata;
    if (ring_re) ring_rd_q <= ring_mem[ring_raddr];
  end

  // process ids of the table
  always_ff @(posedge clk_i) begin
    if (state_q == S_NOW && cmd_q.mode == MODE_SPAWN && free_found) begin
      proc_q[free_idx] <= cmd_q.process_id;
    end
  end

  mlfq_div #(.DW(64), .VW(VW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // command sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_med_q    <= THR_MED_RST;
      thr_low_q    <= THR_LOW_RST;
      alpha_q      <= ALPHA_RST;
      beta_q       <= BETA_RST;
      base_q_q     <= BASE_Q_RST;
      div_med_q    <= DIV_MED_RST;
      div_low_q    <= DIV_LOW_RST;
      state_q      <= S_IDLE;
      for (int i = 0; i < MAX_PROCS; i++) begin
        valid_q[i] <= 1'b0;
        run_q[i]   <= RUN_READY;
        prio_q[i]  <= PRI_TOP;
      end
      for (int r = 0; r < 3; r++) begin
        head_q[r] <= '0;
        tail_q[r] <= '0;
        len_q[r]  <= '0;
      end
      disp_valid_q <= 1'b0;
      disp_proc_q  <= '0;
      rsp_valid_q  <= 1'b0;
      rsp_data_q   <= '0;
      cmd_q        <= '0;
      res_q        <= '0;
      mul_q        <= '0;
      now_q        <= '0;
      nc_q         <= '0;
      nc_ok_q      <= 1'b0;
      w_q          <= '0;
      sum_q        <= '0;
      avg_q        <= '0;
      prod_q       <= '0;
      e_q          <= '0;
      pos_q        <= '0;
      k_q          <= '0;
      rq_q         <= PRI_TOP;
      p_q          <= PRI_TOP;
    end else begin
      // register writes
      if (cfg_i.valid) begin
        unique case (cfg_i.data.index)
          CFG_THR_MED: thr_med_q <= cfg_i.data.data;
          CFG_THR_LOW: thr_low_q <= cfg_i.data.data;
          CFG_ALPHA:   alpha_q   <= cfg_i.data.data[3:0];
          CFG_BETA:    beta_q    <= cfg_i.data.data[3:0];
          CFG_BASE_Q:  base_q_q  <= cfg_i.data.data[31:0];
          CFG_DIV_MED: div_med_q <= cfg_i.data.data[3:0];
          CFG_DIV_LOW: div_low_q <= cfg_i.data.data[3:0];
          default: ;
        endcase
      end

      // drop the output word once taken
      if (rsp_o.ready && state_q != S_DONE) rsp_valid_q <= 1'b0;

      unique case (state_q)
        S_IDLE: begin
          if (cmd_i.valid) begin
            cmd_q   <= cmd_i.data;
            mul_q   <= 62'(cmd_i.data.now_sec) * NS_PER_SEC;
            res_q   <= '0;
            state_q <= S_NOW;
          end
        end
        S_NOW: begin
          now_q <= now_d;
          unique case (cmd_q.mode)
            MODE_SPAWN: begin
              state_q <= S_DONE;
              if (!free_found) begin
                res_q.status <= ST_FULL;
              end else begin
                valid_q[free_idx] <= 1'b1;
                run_q[free_idx]   <= RUN_READY;
                prio_q[free_idx]  <= PRI_TOP;
                if (push_ok) begin
                  if (len_q[PRI_TOP] == '0) head_q[PRI_TOP] <= '0;
                  tail_q[PRI_TOP] <= push_pos;
                  len_q[PRI_TOP]  <= len_q[PRI_TOP] + 1'b1;
                end
              end
            end
            MODE_DEATH: begin
              if (!look_found) begin
                res_q.status <= ST_UNKNOWN;
                state_q      <= S_DONE;
              end else begin
                res_q.priority_res <= prio_q[look_idx];
                valid_q[look_idx]  <= 1'b0;
                if (disp_valid_q && disp_proc_q == cmd_q.process_id) disp_valid_q <= 1'b0;
                e_q     <= look_idx;
                rq_q    <= prio_q[look_idx];
                k_q     <= '0;
                pos_q   <= head_q[prio_q[look_idx]];
                state_q <= S_RM_RD;
              end
            end
            MODE_SELECT: begin
              if (!sel_any) begin
                res_q.status <= ST_NOREADY;
                state_q      <= S_DONE;
              end else begin
                head_q[sel_q] <= pinc(head_q[sel_q]);
                len_q[sel_q]  <= len_q[sel_q] - 1'b1;
                state_q       <= S_SEL_RD;
              end
            end
            MODE_YIELD: begin
              if (!look_found) begin
                res_q.status <= ST_UNKNOWN;
                state_q      <= S_DONE;
              end else begin
                e_q     <= look_idx;
                state_q <= S_Y_SUB;
              end
            end
            MODE_WAIT: begin
              state_q <= S_DONE;
              if (!look_found) begin
                res_q.status <= ST_UNKNOWN;
              end else begin
                run_q[look_idx]    <= RUN_WAIT;
                disp_valid_q       <= 1'b0;
                res_q.priority_res <= prio_q[look_idx];
              end
            end
            default: state_q <= S_DONE;
          endcase
        end
        // find the entry in its ring
        S_RM_RD: state_q <= (k_q == rlen) ? S_DONE : S_RM_CHK;
        S_RM_CHK: begin
          if (ring_rd_q == e_q) begin
            state_q <= S_SH_RD;
          end else begin
            k_q     <= k_q + 1'b1;
            pos_q   <= pinc(pos_q);
            state_q <= S_RM_RD;
          end
        end
        // close the gap, then shorten the ring
        S_SH_RD: begin
          if (({1'b0, k_q} + 1'b1) < {1'b0, rlen}) begin
            state_q <= S_SH_WR;
          end else begin
            len_q[rq_q]  <= rlen - 1'b1;
            tail_q[rq_q] <= pdec(tail_q[rq_q]);
            state_q      <= S_DONE;
          end
        end
        S_SH_WR: begin
          pos_q   <= pinc(pos_q);
          k_q     <= k_q + 1'b1;
          state_q <= S_SH_RD;
        end
        // dispatch the dequeued entry
        S_SEL_RD: begin
          if (!valid_q[ring_rd_q]) begin
            res_q.status <= ST_UNKNOWN;
            state_q      <= S_DONE;
          end else begin
            run_q[ring_rd_q]       <= RUN_RUN;
            res_q.selected_process <= proc_q[ring_rd_q];
            res_q.priority_res     <= prio_q[ring_rd_q];
            disp_valid_q           <= 1'b1;
            disp_proc_q            <= proc_q[ring_rd_q];
            state_q                <= S_SEL_DIV;
          end
        end
        S_SEL_DIV: begin
          if (div_done) begin
            res_q.quantum <= div_quo[31:0];
            state_q       <= S_DONE;
          end
        end
        // burst wait
        S_Y_SUB: begin
          nc_q    <= now_q - 64'(cmd_q.burst_cpu);
          nc_ok_q <= now_q >= 64'(cmd_q.burst_cpu);
          state_q <= S_Y_CALC;
        end
        S_Y_CALC: begin
          w_q     <= (nc_ok_q && nc_q >= ent_rd_q.last) ? nc_q - ent_rd_q.last : 64'd0;
          state_q <= S_Y_WR;
        end
        S_Y_WR: begin
          run_q[e_q]       <= RUN_READY;
          disp_valid_q     <= 1'b0;
          res_q.burst_wait <= w_q[62:0];
          p_q              <= prio_q[e_q];
          k_q              <= '0;
          sum_q            <= '0;
          if (w_q > 64'(thr_med_q)) begin
            rq_q    <= PRI_MID;
            pos_q   <= head_q[PRI_MID];
            state_q <= S_AV_RD;
          end else if (w_q > 64'(thr_low_q)) begin
            rq_q    <= PRI_BOT;
            pos_q   <= head_q[PRI_BOT];
            state_q <= S_AV_RD;
          end else begin
            state_q <= S_PUSH;
          end
        end
        // average total wait of ring rq
        S_AV_RD: begin
          if (k_q == rlen) begin
            avg_q   <= '0;
            state_q <= (rlen == '0) ? S_AV_MUL : S_AV_DIV;
          end else begin
            state_q <= S_AV_ENT;
          end
        end
        S_AV_ENT: state_q <= S_AV_ACC;
        S_AV_ACC: begin
          sum_q   <= sum_q + ent_rd_q.wait_sum;
          k_q     <= k_q + 1'b1;
          pos_q   <= pinc(pos_q);
          state_q <= S_AV_RD;
        end
        S_AV_DIV: begin
          if (div_done) begin
            avg_q   <= div_quo;
            state_q <= S_AV_MUL;
          end
        end
        S_AV_MUL: begin
          prod_q  <= 68'((rq_q == PRI_MID) ? alpha_q : beta_q) * 68'(avg_q);
          state_q <= S_AV_CMP;
        end
        S_AV_CMP: begin
          if (68'(w_q) > prod_q) begin
            p_q     <= rq_q;
            state_q <= S_PUSH;
          end else if (rq_q == PRI_MID && w_q > 64'(thr_low_q)) begin
            rq_q    <= PRI_BOT;
            k_q     <= '0;
            sum_q   <= '0;
            pos_q   <= head_q[PRI_BOT];
            state_q <= S_AV_RD;
          end else begin
            state_q <= S_PUSH;
          end
        end
        // requeue at the new priority
        S_PUSH: begin
          prio_q[e_q]        <= p_q;
          res_q.priority_res <= p_q;
          if (push_ok) begin
            if (len_q[p_q] == '0) head_q[p_q] <= '0;
            tail_q[p_q] <= push_pos;
            len_q[p_q]  <= len_q[p_q] + 1'b1;
          end
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (!rsp_valid_q || rsp_o.ready) begin
            rsp_valid_q <= 1'b1;
            rsp_data_q  <= res_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign cmd_i.ready = state_q == S_IDLE;
  assign cfg_i.ready = 1'b1;
  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.data  = rsp_data_q;

  // checks
  a_accept_starts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.valid && cmd_i.ready) |=> (state_q == S_NOW))
    else $error("accepted command did not start");

  a_div_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_ring_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (len_q[PRI_TOP] <= LW'(MAX_PROCS)) && (len_q[PRI_MID] <= LW'(MAX_PROCS))
    && (len_q[PRI_BOT] <= LW'(MAX_PROCS)))
    else $error("ring length beyond table size");

  a_done_emits : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && !rsp_valid_q) |=> (rsp_valid_q && state_q == S_IDLE))
    else $error("finished word not presented");

endmodule
